// ----- design/round_robin_thread_scheduler_top_macros.svh -----
// assertion macros for the round-robin thread scheduler
// expects clk and rst_n in the scope of the module that includes it
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_TOP_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define RRTS_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define RRTS_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define RRTS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/rrts_pkg.sv -----
// shared types and constants for the round-robin thread scheduler
// no dependencies
package rrts_pkg;

    localparam int MAX_THREADS = 16;
    localparam int THREAD_W    = $clog2(MAX_THREADS);
    localparam int COUNT_W     = $clog2(MAX_THREADS + 1);

    typedef logic [THREAD_W-1:0] thread_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [1:0]          kind_t;

    localparam kind_t KIND_READY = 2'd0;
    localparam kind_t KIND_BLOCK = 2'd1;
    localparam kind_t KIND_SCHED = 2'd2;

    typedef enum logic [1:0] {
        ST_ABSENT   = 2'd0,
        ST_RUNNABLE = 2'd1,
        ST_BLOCKED  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UNLINK,
        S_ROTATE,
        S_PUSH,
        S_OUT
    } state_t;

    // write requests to the next-link and previous-link memories
    typedef struct packed {
        logic    nxt_we;
        thread_t nxt_addr;
        thread_t nxt_data;
        logic    prv_we;
        thread_t prv_addr;
        thread_t prv_data;
    } link_wr_t;

endpackage

// ----- design/round_robin_thread_scheduler_top.sv -----
// round-robin thread scheduler: runnable list kept as a doubly linked list
// depends on rrts_pkg, rrts_link_store and round_robin_thread_scheduler_top_macros.svh
//
// channel   handshake              payload
// request   req_valid / req_stall  kind, thread_id
// response  rsp_valid / rsp_stall  current_thread, current_valid, ready_count
//
// one request at a time; block of a non-runnable thread, plain schedule or no-op go
// straight to the output step; block with unlink, rotating schedule or ready of a
// non-runnable thread take one list step first; ready of a runnable thread that is not the head
// unlinks then pushes; the steps are split by the registered read data of the link memories
// reset clears list, status and current thread at once; link memories need no clearing
// a stalled response holds the block in its last step; the next request waits for it
`include "round_robin_thread_scheduler_top_macros.svh"

module round_robin_thread_scheduler_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  rrts_pkg::kind_t   kind,
    input  rrts_pkg::thread_t thread_id,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rrts_pkg::thread_t current_thread,
    output logic              current_valid,
    output rrts_pkg::count_t  ready_count
);
    import rrts_pkg::*;

    state_t   state_reg, state_next;
    thread_t  head_reg, head_next;
    thread_t  tail_reg, tail_next;
    count_t   count_reg, count_next;
    thread_t  running_thread_reg, running_thread_next;
    logic     running_valid_reg, running_valid_next;
    kind_t    op_kind_reg, op_kind_next;
    thread_t  op_thread_reg, op_thread_next;
    status_t  status_reg [MAX_THREADS];
    status_t  status_next [MAX_THREADS];
    logic     rsp_valid_reg, rsp_valid_next;
    thread_t  rsp_thread_reg, rsp_thread_next;
    logic     rsp_cur_valid_reg, rsp_cur_valid_next;
    count_t   rsp_count_reg, rsp_count_next;

    thread_t  rd_addr;
    link_wr_t link_wr;
    thread_t  nxt_q;
    thread_t  prv_q;

    logic     req_accept;
    logic     hit_head;
    logic     is_runnable;
    logic     rotate_cond;
    logic     rsp_free;
    logic [MAX_THREADS-1:0] runnable_vec;

    rrts_link_store u_links (
        .clk     (clk),
        .rd_addr (rd_addr),
        .wr      (link_wr),
        .nxt_q   (nxt_q),
        .prv_q   (prv_q)
    );

    assign req_stall   = (state_reg != S_IDLE);
    assign req_accept  = req_valid && !req_stall;
    assign hit_head    = (count_reg != '0) && (head_reg == thread_id);
    assign is_runnable = (status_reg[thread_id] == ST_RUNNABLE);
    assign rotate_cond = running_valid_reg && (running_thread_reg == head_reg)
                         && (count_reg > count_t'(1));
    assign rsp_free    = !rsp_valid_reg || !rsp_stall;
    assign rd_addr     = (kind == KIND_SCHED) ? head_reg : thread_id;

    always_comb
    begin
        for (int i = 0; i < MAX_THREADS; i++)
        begin
            runnable_vec[i] = (status_reg[i] == ST_RUNNABLE);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    case (kind)
                        KIND_READY:
                        begin
                            if (hit_head)
                            begin
                                state_next = S_OUT;
                            end
                            else if (is_runnable)
                            begin
                                state_next = S_UNLINK;
                            end
                            else
                            begin
                                state_next = S_PUSH;
                            end
                        end
                        KIND_BLOCK:
                        begin
                            state_next = is_runnable ? S_UNLINK : S_OUT;
                        end
                        KIND_SCHED:
                        begin
                            state_next = rotate_cond ? S_ROTATE : S_OUT;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_UNLINK:
            begin
                state_next = (op_kind_reg == KIND_READY) ? S_PUSH : S_OUT;
            end
            S_ROTATE:
            begin
                state_next = S_OUT;
            end
            S_PUSH:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // list updates and response
    always_comb
    begin
        head_next           = head_reg;
        tail_next           = tail_reg;
        count_next          = count_reg;
        running_thread_next = running_thread_reg;
        running_valid_next  = running_valid_reg;
        op_kind_next        = op_kind_reg;
        op_thread_next      = op_thread_reg;
        status_next         = status_reg;
        rsp_valid_next      = rsp_valid_reg && rsp_stall;
        rsp_thread_next     = rsp_thread_reg;
        rsp_cur_valid_next  = rsp_cur_valid_reg;
        rsp_count_next      = rsp_count_reg;
        link_wr             = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    op_kind_next   = kind;
                    op_thread_next = thread_id;
                    case (kind)
                        KIND_READY:
                        begin
                            if (!hit_head)
                            begin
                                status_next[thread_id] = ST_RUNNABLE;
                            end
                        end
                        KIND_BLOCK:
                        begin
                            status_next[thread_id] = ST_BLOCKED;
                        end
                        KIND_SCHED:
                        begin
                            if (count_reg == '0)
                            begin
                                running_valid_next  = 1'b0;
                                running_thread_next = '0;
                            end
                            else if (!rotate_cond)
                            begin
                                running_valid_next  = 1'b1;
                                running_thread_next = head_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_UNLINK:
            begin
                if (op_thread_reg == head_reg)
                begin
                    head_next = nxt_q;
                end
                else
                begin
                    link_wr.nxt_we   = 1'b1;
                    link_wr.nxt_addr = prv_q;
                    link_wr.nxt_data = nxt_q;
                end
                if (op_thread_reg == tail_reg)
                begin
                    tail_next = prv_q;
                end
                else
                begin
                    link_wr.prv_we   = 1'b1;
                    link_wr.prv_addr = nxt_q;
                    link_wr.prv_data = prv_q;
                end
                count_next = count_reg - count_t'(1);
            end
            S_ROTATE:
            begin
                link_wr.nxt_we      = 1'b1;
                link_wr.nxt_addr    = tail_reg;
                link_wr.nxt_data    = head_reg;
                link_wr.prv_we      = 1'b1;
                link_wr.prv_addr    = head_reg;
                link_wr.prv_data    = tail_reg;
                head_next           = nxt_q;
                tail_next           = head_reg;
                running_thread_next = nxt_q;
                running_valid_next  = 1'b1;
            end
            S_PUSH:
            begin
                if (count_reg == '0)
                begin
                    tail_next = op_thread_reg;
                end
                else
                begin
                    link_wr.nxt_we   = 1'b1;
                    link_wr.nxt_addr = op_thread_reg;
                    link_wr.nxt_data = head_reg;
                    link_wr.prv_we   = 1'b1;
                    link_wr.prv_addr = head_reg;
                    link_wr.prv_data = op_thread_reg;
                end
                head_next  = op_thread_reg;
                count_next = count_reg + count_t'(1);
            end
            S_OUT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_thread_next    = running_valid_reg ? running_thread_reg : '0;
                    rsp_cur_valid_next = running_valid_reg;
                    rsp_count_next     = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            head_reg           <= '0;
            tail_reg           <= '0;
            count_reg          <= '0;
            running_thread_reg <= '0;
            running_valid_reg  <= 1'b0;
            rsp_valid_reg      <= 1'b0;
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                status_reg[i] <= ST_ABSENT;
            end
        end
        else
        begin
            state_reg          <= state_next;
            head_reg           <= head_next;
            tail_reg           <= tail_next;
            count_reg          <= count_next;
            running_thread_reg <= running_thread_next;
            running_valid_reg  <= running_valid_next;
            rsp_valid_reg      <= rsp_valid_next;
            status_reg         <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_kind_reg       <= op_kind_next;
        op_thread_reg     <= op_thread_next;
        rsp_thread_reg    <= rsp_thread_next;
        rsp_cur_valid_reg <= rsp_cur_valid_next;
        rsp_count_reg     <= rsp_count_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign current_thread = rsp_thread_reg;
    assign current_valid  = rsp_cur_valid_reg;
    assign ready_count    = rsp_count_reg;

    `RRTS_ASSERT_IMPLIES(a_count_matches_status, state_reg == S_IDLE,
        $countones(runnable_vec) == int'(count_reg), "ready count disagrees with status")
    `RRTS_ASSERT_IMPLIES(a_idle_running_zero, !running_valid_reg,
        running_thread_reg == '0, "no current thread but thread number not zero")
    `RRTS_ASSERT_IMPLIES(a_rotate_needs_two, state_reg == S_ROTATE,
        count_reg > count_t'(1), "rotation with fewer than two runnable threads")
    `RRTS_ASSERT_NEXT(a_accept_leaves_idle, req_accept,
        state_reg != S_IDLE, "request accepted but block stayed idle")
    `RRTS_ASSERT_NEXT(a_out_loads_rsp, state_reg == S_OUT && rsp_free,
        rsp_valid_reg && state_reg == S_IDLE, "response not loaded on finish")

endmodule

// ----- design/rrts_link_store.sv -----
// next and previous link memories of the runnable list, indexed by thread
// one shared read address, registered read data; depends on rrts_pkg
module rrts_link_store (
    input  logic              clk,
    input  rrts_pkg::thread_t rd_addr,
    input  rrts_pkg::link_wr_t wr,
    output rrts_pkg::thread_t nxt_q,
    output rrts_pkg::thread_t prv_q
);
    import rrts_pkg::*;

    thread_t nxt_mem [MAX_THREADS];
    thread_t prv_mem [MAX_THREADS];
    thread_t nxt_q_reg;
    thread_t prv_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr.nxt_we)
        begin
            nxt_mem[wr.nxt_addr] <= wr.nxt_data;
        end
        if (wr.prv_we)
        begin
            prv_mem[wr.prv_addr] <= wr.prv_data;
        end
        nxt_q_reg <= nxt_mem[rd_addr];
        prv_q_reg <= prv_mem[rd_addr];
    end

    assign nxt_q = nxt_q_reg;
    assign prv_q = prv_q_reg;

endmodule
